/* hw/rtl/fcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types, opcodes and the crc-8 step for the command frame builder.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam logic [1:0] OP_START_HW = 2'd0;
  localparam logic [1:0] OP_START_BL = 2'd1;
  localparam logic [1:0] OP_PARAM    = 2'd2;

  localparam int unsigned MAX_BYTES  = 6;
  localparam logic [15:0] HW_HDR_LEN = 16'd6;
  localparam logic [7:0]  CRC_POLY   = 8'h8C;

  typedef logic [2:0] cnt_t;

  // bytes one item puts on the output, crc byte last when close is set
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    cnt_t                      n;
    logic                      close;
  } burst_t;

  typedef struct packed {
    logic   load;
    burst_t burst;
  } ld_req_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fcb_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_in_if
// Input channel of the frame builder: one command word per handshake.
// ----------------------------------------------------------------------------
interface fcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] cmd_code;
  logic [7:0]  device;
  logic [15:0] param_len;
  logic        has_params;
  logic [7:0]  data_byte;

  modport source (output valid, op, cmd_code, device, param_len, has_params, data_byte,
                  input ready);
  modport sink   (input valid, op, cmd_code, device, param_len, has_params, data_byte,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/fcb_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_out_if
// Result channel of the frame builder: one frame byte per handshake.
// ----------------------------------------------------------------------------
interface fcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, out_byte, frame_end, run_last, input ready);
  modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/command_frame_builder_crc8.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_builder_crc8
// Builds command frames byte by byte with a trailing reflected crc-8.
// ----------------------------------------------------------------------------
// order: a word waits in the input register until the serializer can load it,
//   and the serializer then offers its first byte
// throughput: bytes leave one per cycle through the output serializer while
//   the receiver is ready (start: 3 to 6, parameter: 0 to 2)
// reset: synchronous active-low rst_n clears the pipeline and frame state
// ----------------------------------------------------------------------------
module command_frame_builder_crc8
  import fcb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  fcb_in_if.sink    in_ch,
  fcb_out_if.source out_ch
);

  ld_req_t ld_req;
  logic    load_ok;

  fcb_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .load_ok (load_ok),
    .ld_req  (ld_req)
  );

  fcb_out_ser u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_req  (ld_req),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

/* hw/rtl/fcb_frame_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_frame_ctrl
// Input register, frame state and per-word byte burst generation.
// ----------------------------------------------------------------------------
module fcb_frame_ctrl
  import fcb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  fcb_in_if.sink       in_ch,
  input  wire logic    load_ok,
  output wire ld_req_t ld_req
);

  logic        item_v_r;
  logic [1:0]  op_r;
  logic [15:0] code_r;
  logic [7:0]  dev_r;
  logic [15:0] plen_r;
  logic        has_r;
  logic [7:0]  data_r;

  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  crc_r, crc_nxt;

  burst_t      burst;
  logic        adv;
  logic        in_take;
  logic [15:0] count;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic [7:0]  c0, c1, c2, c3, c4;

  // words with no bytes retire without waiting for the serializer
  assign adv          = item_v_r && ((burst.n == cnt_t'(0)) || load_ok);
  assign in_ch.ready  = !item_v_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign ld_req.load  = adv && (burst.n != cnt_t'(0));
  assign ld_req.burst = burst;

  assign count    = has_r ? plen_r : 16'd0;
  assign len      = HW_HDR_LEN + count;
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    burst          = '0;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    c0 = '0; c1 = '0; c2 = '0; c3 = '0; c4 = '0;
    case (op_r)
      OP_START_HW: begin
        burst.bytes[0] = len[15:8];
        burst.bytes[1] = len[7:0];
        burst.bytes[2] = code_r[15:8];
        burst.bytes[3] = code_r[7:0];
        burst.bytes[4] = dev_r;
        c0 = crc8_upd(8'd0, len[15:8]);
        c1 = crc8_upd(c0, len[7:0]);
        c2 = crc8_upd(c1, code_r[15:8]);
        c3 = crc8_upd(c2, code_r[7:0]);
        c4 = crc8_upd(c3, dev_r);
        if (count == 16'd0) begin
          burst.bytes[5] = c4;
          burst.n        = cnt_t'(6);
          burst.close    = 1'b1;
          frame_open_nxt = 1'b0;
          bytes_left_nxt = 16'd0;
          crc_nxt        = 8'd0;
        end else begin
          burst.n        = cnt_t'(5);
          frame_open_nxt = 1'b1;
          bytes_left_nxt = count;
          crc_nxt        = c4;
        end
      end
      OP_START_BL: begin
        burst.bytes[0] = code_r[7:0];
        burst.bytes[1] = plen_r[15:8];
        burst.bytes[2] = plen_r[7:0];
        c0 = crc8_upd(8'd0, code_r[7:0]);
        c1 = crc8_upd(c0, plen_r[15:8]);
        c2 = crc8_upd(c1, plen_r[7:0]);
        if (count == 16'd0) begin
          burst.bytes[3] = c2;
          burst.n        = cnt_t'(4);
          burst.close    = 1'b1;
          frame_open_nxt = 1'b0;
          bytes_left_nxt = 16'd0;
          crc_nxt        = 8'd0;
        end else begin
          burst.n        = cnt_t'(3);
          frame_open_nxt = 1'b1;
          bytes_left_nxt = count;
          crc_nxt        = c2;
        end
      end
      OP_PARAM: begin
        // stray bytes with no open frame are dropped
        if (frame_open_r && (bytes_left_r != 16'd0)) begin
          burst.bytes[0] = data_r;
          c0             = crc8_upd(crc_r, data_r);
          bytes_left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            burst.bytes[1] = c0;
            burst.n        = cnt_t'(2);
            burst.close    = 1'b1;
            frame_open_nxt = 1'b0;
            crc_nxt        = 8'd0;
          end else begin
            burst.n = cnt_t'(1);
            crc_nxt = c0;
          end
        end
      end
      default: begin
        burst = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
      crc_r        <= '0;
    end else begin
      if (in_take) begin
        item_v_r <= 1'b1;
      end else if (adv) begin
        item_v_r <= 1'b0;
      end
      if (adv) begin
        frame_open_r <= frame_open_nxt;
        bytes_left_r <= bytes_left_nxt;
        crc_r        <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_ch.op;
      code_r <= in_ch.cmd_code;
      dev_r  <= in_ch.device;
      plen_r <= in_ch.param_len;
      has_r  <= in_ch.has_params;
      data_r <= in_ch.data_byte;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fcb_out_ser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_out_ser
// Result register: holds one byte burst and sends it a byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module fcb_out_ser
  import fcb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ld_req_t ld_req,
  output logic         load_ok,
  fcb_out_if.source    out_ch
);

  burst_t burst_r;
  cnt_t   idx_r;
  logic   busy_r;
  logic   last;
  logic   take;

  assign last    = (idx_r == (burst_r.n - cnt_t'(1)));
  assign take    = busy_r && out_ch.ready;
  // a new burst may load in the cycle the last byte leaves
  assign load_ok = !busy_r || (take && last);

  assign out_ch.valid     = busy_r;
  assign out_ch.out_byte  = burst_r.bytes[idx_r];
  assign out_ch.run_last  = last;
  assign out_ch.frame_end = last && burst_r.close;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (ld_req.load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (take) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + cnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_req.load) begin
      burst_r <= ld_req.burst;
    end
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command frame builder. Command words go in
// through the input channel in random bursts and every frame byte that comes
// out is compared against an in-bench model of the header layout, the
// parameter count and the running crc-8. The receiver stalls in random runs
// and once holds off long enough to back the builder up.
// ----------------------------------------------------------------------------
module tb_top
  import fcb_pkg::*;
();

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         DRAIN_WAIT  = 20;
  localparam int         CYCLE_LIMIT = 200000;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] cmd_code;
    logic [7:0]  device;
    logic [15:0] param_len;
    logic        has_params;
    logic [7:0]  data_byte;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  fcb_in_if  in_ch ();
  fcb_out_if out_ch ();

  command_frame_builder_crc8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model state
  logic        mdl_open;
  logic [15:0] mdl_params_due;
  logic [7:0]  mdl_crc;
  frame_byte_t word_bytes[$];
  frame_byte_t due_bytes[$];

  // traffic shaping
  int gap_max;
  int stall_pct;
  int burst_left;
  bit hold_req;
  int held;

  // bookkeeping
  int words_sent;
  int bytes_checked;
  int frames_closed;
  int err_cnt;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reflected crc-8, one bit at a time from the lsb
  function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void add_frame_byte(input logic [7:0] b);
    frame_byte_t fb;
    fb.out_byte  = b;
    fb.frame_end = 1'b0;
    fb.run_last  = 1'b0;
    word_bytes.push_back(fb);
    mdl_crc = crc8_bitwise(mdl_crc, b);
  endfunction

  // works out the frame bytes one accepted word yields and queues them
  function automatic void model_frame_word(input cmd_word_t w);
    logic [15:0] count;
    logic [15:0] flen;
    frame_byte_t fb;
    word_bytes.delete();
    count = w.has_params ? w.param_len : 16'd0;
    case (w.op)
      OP_START_HW: begin
        flen           = HW_HDR_LEN + count;
        mdl_crc        = 8'h00;
        mdl_open       = 1'b1;
        mdl_params_due = count;
        add_frame_byte(flen[15:8]);
        add_frame_byte(flen[7:0]);
        add_frame_byte(w.cmd_code[15:8]);
        add_frame_byte(w.cmd_code[7:0]);
        add_frame_byte(w.device);
      end
      OP_START_BL: begin
        mdl_crc        = 8'h00;
        mdl_open       = 1'b1;
        mdl_params_due = count;
        add_frame_byte(w.cmd_code[7:0]);
        add_frame_byte(w.param_len[15:8]);
        add_frame_byte(w.param_len[7:0]);
      end
      OP_PARAM: begin
        if (mdl_open && mdl_params_due != 16'd0) begin
          add_frame_byte(w.data_byte);
          mdl_params_due = mdl_params_due - 16'd1;
        end
      end
      default: ;
    endcase
    // crc closes the frame once no parameter bytes are left
    if (word_bytes.size() > 0 && mdl_params_due == 16'd0) begin
      fb.out_byte  = mdl_crc;
      fb.frame_end = 1'b1;
      fb.run_last  = 1'b0;
      word_bytes.push_back(fb);
      mdl_open = 1'b0;
      mdl_crc  = 8'h00;
    end
    foreach (word_bytes[i]) begin
      fb          = word_bytes[i];
      fb.run_last = (i == word_bytes.size() - 1);
      due_bytes.push_back(fb);
    end
  endfunction

  function automatic cmd_word_t mk_word(input logic [1:0] op, input logic [15:0] code,
                                        input logic [7:0] dev, input logic [15:0] plen,
                                        input logic has, input logic [7:0] data);
    cmd_word_t w;
    w.op         = op;
    w.cmd_code   = code;
    w.device     = dev;
    w.param_len  = plen;
    w.has_params = has;
    w.data_byte  = data;
    return w;
  endfunction

  function automatic cmd_word_t rand_word(input logic [1:0] op);
    return mk_word(op, 16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                   8'($urandom));
  endfunction

  // drives one word and waits for it to be taken
  task automatic send_word(input cmd_word_t w);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, gap_max - 1)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.op         = w.op;
    in_ch.cmd_code   = w.cmd_code;
    in_ch.device     = w.device;
    in_ch.param_len  = w.param_len;
    in_ch.has_params = w.has_params;
    in_ch.data_byte  = w.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    model_frame_word(w);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_frame(input logic [1:0] op, input logic [15:0] plen, input int n_params);
    cmd_word_t w;
    w            = rand_word(op);
    w.param_len  = plen;
    w.has_params = 1'b1;
    send_word(w);
    repeat (n_params) send_word(rand_word(OP_PARAM));
  endtask

  // stop offering the last word before waiting for the output to empty
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    gap_max   = 3;
    stall_pct = 30;
    // parameter byte with no frame open
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'hFF));
    send_word(mk_word(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF));
    // count forced to zero when no parameters follow
    send_word(mk_word(OP_START_HW, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 8'h00));
    send_word(mk_word(OP_START_HW, 16'h0000, 8'h00, 16'h0000, 1'b1, 8'hFF));
    send_word(mk_word(OP_START_BL, 16'hFFFF, 8'h00, 16'hFFFF, 1'b0, 8'h00));
    send_word(mk_word(OP_START_BL, 16'h1200, 8'hFF, 16'h0000, 1'b1, 8'h00));
    // complete frames with extreme parameter values
    send_word(mk_word(OP_START_HW, 16'hA55A, 8'h3C, 16'h0003, 1'b1, 8'h00));
    send_word(mk_word(OP_PARAM, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 8'h00));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'hFF));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h5A));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h77));
    send_word(mk_word(OP_START_BL, 16'h00C3, 8'h99, 16'h0002, 1'b1, 8'h00));
    send_word(mk_word(OP_UNUSED, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h00));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h81));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h7E));
    // length field wraps, frame abandoned by the next start
    send_word(mk_word(OP_START_HW, 16'h0102, 8'h03, 16'hFFFF, 1'b1, 8'h00));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h11));
    send_word(mk_word(OP_START_HW, 16'h8001, 8'h80, 16'hFFFA, 1'b1, 8'h00));
    send_word(mk_word(OP_START_BL, 16'h7FFE, 8'h01, 16'h8000, 1'b1, 8'h00));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'h42));
    send_word(mk_word(OP_START_HW, 16'h00FF, 8'h7F, 16'h0001, 1'b1, 8'h00));
    send_word(mk_word(OP_PARAM, 16'h0000, 8'h00, 16'h0000, 1'b0, 8'hC0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_words);
    int first;
    int r;
    int n;
    cmd_word_t w;
    first = words_sent;
    while (words_sent - first < n_words) begin
      // new idling profile every few dozen words, some with none at all
      if (((words_sent - first) % 40) < 2) begin
        case ($urandom_range(0, 3))
          0: begin gap_max = 0; stall_pct = 0;  end
          1: begin gap_max = 2; stall_pct = 20; end
          2: begin gap_max = 6; stall_pct = 50; end
          default: begin gap_max = 0; stall_pct = 70; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        send_frame($urandom_range(0, 1) ? OP_START_BL : OP_START_HW, 16'(n), n);
      end else if (r < 73) begin
        w            = rand_word($urandom_range(0, 1) ? OP_START_BL : OP_START_HW);
        w.has_params = 1'b0;
        send_word(w);
      end else if (r < 83) begin
        // broken frame: big count, only a few bytes, then abandoned
        send_frame($urandom_range(0, 1) ? OP_START_BL : OP_START_HW, 16'($urandom),
                   $urandom_range(0, 4));
      end else if (r < 93) begin
        send_word(rand_word(OP_PARAM));
      end else begin
        send_word(rand_word(OP_UNUSED));
      end
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    send_frame(OP_START_HW, 16'd24, 24);
    send_frame(OP_START_BL, 16'd3, 3);
    wait_drained();
  endtask

  // receiver: ready in random runs, plus one long hold-off on request
  initial begin : rx_ready_gen
    bit run_ready;
    int run_left;
    run_ready = 1'b1;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_ch.ready = 1'b0;
        held++;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 99) >= stall_pct);
          run_left  = $urandom_range(1, 5);
        end
        out_ch.ready = run_ready;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : frame_byte_check
    frame_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (out_ch.frame_end) begin
        frames_closed++;
      end
      if (due_bytes.size() == 0) begin
        $error("unexpected frame byte 0x%02h", out_ch.out_byte);
        err_cnt++;
      end else begin
        want = due_bytes.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_ch.out_byte);
          err_cnt++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
          err_cnt++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d bytes outstanding", cycle_cnt, due_bytes.size());
    $display("[command_frame_builder_crc8] ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_UNUSED;
    in_ch.cmd_code   = 16'h0000;
    in_ch.device     = 8'h00;
    in_ch.param_len  = 16'h0000;
    in_ch.has_params = 1'b0;
    in_ch.data_byte  = 8'h00;
    out_ch.ready     = 1'b0;
    mdl_open         = 1'b0;
    mdl_params_due   = 16'h0000;
    mdl_crc          = 8'h00;
    gap_max          = 0;
    stall_pct        = 0;
    burst_left       = 0;
    hold_req         = 1'b0;
    held             = 0;
    words_sent       = 0;
    bytes_checked    = 0;
    frames_closed    = 0;
    err_cnt          = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_traffic(205);
    test_output_backpressure();

    @(negedge clk);
    in_ch.valid = 1'b0;
    stall_pct   = 0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_bytes.size() != 0) begin
      $error("%0d frame bytes never arrived", due_bytes.size());
      err_cnt++;
    end

    $display("covered %0d command words: %0d frame bytes checked, %0d frames closed",
             words_sent, bytes_checked, frames_closed);
    $display("mismatches: %0d, cycles: %0d", err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("[command_frame_builder_crc8] OK");
    end else begin
      $display("[command_frame_builder_crc8] ERROR");
    end
    $finish;
  end

endmodule
